// File: rtl/usvt_pkg.sv
// usvt_pkg: operation codes and fixed port widths of the unique value set table.
// No dependencies; used by unique_value_set_table.
package usvt_pkg;

  // Port widths fixed by the item format
  localparam int KIND_W  = 2;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 6;

  // Operation codes; any other code behaves as a query
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ERASE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

endpackage

// File: rtl/unique_value_set_table.sv
// unique_value_set_table: set of distinct values held in one synchronous RAM.
// Depends on usvt_pkg (operation codes, port widths).
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------------
//  command   | start, busy          | kind, value
//  result    | done (one cycle)     | was_present, applied, rejected_full,
//            |                      | entry_count
//
// A command scans the held entries through the single RAM read port, one entry per
// cycle, in a linear search; a match ends the scan early, and an empty set skips it.
// An erase whose match is not the last entry moves the last entry into the hole
// through an extra swap state before its result is reported.
// The result strobe rises the cycle busy falls; a new command may be taken
// in that same cycle. Reset empties the set at once (no clearing pass).
// The receiver cannot stall: each result is shown for exactly one cycle.
module unique_value_set_table #(
  parameter int CAPACITY_ENTRIES = 32,
  parameter int VALUE_BITS       = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [usvt_pkg::KIND_W-1:0] kind,
  input  logic [usvt_pkg::VALUE_W-1:0] value,
  output logic                        done,
  output logic                        was_present,
  output logic                        applied,
  output logic                        rejected_full,
  output logic [usvt_pkg::COUNT_W-1:0] entry_count
);

  // Stored width: the port carries at most VALUE_W bits
  localparam int EW = (VALUE_BITS < usvt_pkg::VALUE_W) ? VALUE_BITS : usvt_pkg::VALUE_W;
  localparam int AW = $clog2(CAPACITY_ENTRIES);
  localparam int CW = $clog2(CAPACITY_ENTRIES + 1);
  localparam int XW = (CW > usvt_pkg::COUNT_W) ? CW : usvt_pkg::COUNT_W;
  localparam logic [CW-1:0] CAP = CW'(CAPACITY_ENTRIES);

  // Sequencer codes
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_SWAP   = 2'd3;

  logic [1:0]                  state;
  logic [usvt_pkg::KIND_W-1:0] op;
  logic [EW-1:0]               val;
  logic [CW-1:0]               count;
  logic [CW-1:0]               ridx;
  logic                        pv;
  logic                        found;
  logic [AW-1:0]               slot;

  // Entry RAM, one read and one write port
  logic [EW-1:0] mem [CAPACITY_ENTRIES];
  logic [EW-1:0] rd_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  logic          accept;
  logic          match;
  logic          last_cmp;
  logic [CW-1:0] count_m1;
  logic [XW-1:0] count_x;

  assign accept   = start && !busy;
  assign busy     = (state != ST_IDLE);
  assign count_m1 = count - CW'(1);
  assign match    = pv && (rd_data == val);
  assign last_cmp = pv && (ridx == count);

  // Scan reads walk the array; the swap read fetches the last entry
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AW'(count_m1);
    wr_en   = 1'b0;
    wr_addr = slot;
    wr_data = rd_data;
    case (state)
      ST_SCAN: begin
        rd_en   = (ridx < count);
        rd_addr = AW'(ridx);
      end
      ST_DECIDE: begin
        if (op == usvt_pkg::KIND_INSERT && !found && count < CAP) begin
          wr_en   = 1'b1;
          wr_addr = AW'(count);
          wr_data = val;
        end
        rd_en = (op == usvt_pkg::KIND_ERASE) && found && (CW'(slot) != count_m1);
      end
      ST_SWAP: begin
        wr_en = 1'b1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Sequencer: scan (skipped on an empty set), decide, optional swap, then report
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
      pv    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            op    <= kind;
            val   <= value[EW-1:0];
            ridx  <= '0;
            pv    <= 1'b0;
            found <= 1'b0;
            state <= (count == '0) ? ST_DECIDE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          pv <= rd_en;
          if (rd_en) begin
            ridx <= ridx + CW'(1);
          end
          if (match) begin
            found <= 1'b1;
            slot  <= AW'(ridx - CW'(1));
            state <= ST_DECIDE;
          end else if (last_cmp) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          was_present   <= found;
          applied       <= 1'b0;
          rejected_full <= 1'b0;
          state         <= ST_IDLE;
          done          <= 1'b1;
          if (op == usvt_pkg::KIND_INSERT && !found) begin
            if (count < CAP) begin
              count   <= count + CW'(1);
              applied <= 1'b1;
            end else begin
              rejected_full <= 1'b1;
            end
          end else if (op == usvt_pkg::KIND_ERASE && found) begin
            count   <= count_m1;
            applied <= 1'b1;
            if (rd_en) begin
              // hold the result until the moved entry is written back
              done  <= 1'b0;
              state <= ST_SWAP;
            end
          end
        end
        ST_SWAP: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Count as reported: low bits of the entry count
  assign count_x     = XW'(count);
  assign entry_count = count_x[usvt_pkg::COUNT_W-1:0];

  // Result only once the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // Count never passes capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst) count <= CAP)
    else $error("entry count above capacity");

  // A taken command keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("command taken but block not busy");

  // A change and a full rejection never report together
  a_flags: assert property (@(posedge clk) disable iff (rst)
    done |-> !(applied && rejected_full))
    else $error("applied and rejected_full both set");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for unique_value_set_table.
// Depends on usvt_pkg and the unique_value_set_table RTL; a scoreboard class
// predicts each result from its own copy of the set and checks the done strobe.
module tb_top;

  localparam int KIND_W       = usvt_pkg::KIND_W;
  localparam int VALUE_W      = usvt_pkg::VALUE_W;
  localparam int COUNT_W      = usvt_pkg::COUNT_W;
  localparam int SET_CAPACITY = 32;
  localparam int POOL_SIZE    = 48;
  localparam int RANDOM_ITEMS = 750;

  // Unassigned operation code; the block answers it as a query
  localparam logic [KIND_W-1:0] KIND_OTHER = 2'd3;

  typedef struct packed {
    logic               was_present;
    logic               applied;
    logic               rejected_full;
    logic [COUNT_W-1:0] entry_count;
  } set_answer_t;

  // Predict set answers in issue order and check them against the done strobe
  class value_set_scoreboard;
    logic [VALUE_W-1:0] held_values [SET_CAPACITY];
    int unsigned        held_count;
    set_answer_t        pending_answers [$];
    int unsigned        failures;

    function new();
      held_count = 0;
      failures   = 0;
    endfunction

    // Apply one accepted command to the shadow set and queue its answer
    function void apply_command(logic [KIND_W-1:0] op, logic [VALUE_W-1:0] v);
      int unsigned slot;
      set_answer_t ans;
      slot = 0;
      while (slot < held_count && held_values[slot] != v) slot++;
      ans = '0;
      ans.was_present = (slot < held_count);
      case (op)
        usvt_pkg::KIND_INSERT: begin
          if (!ans.was_present) begin
            if (held_count < SET_CAPACITY) begin
              held_values[held_count] = v;
              held_count++;
              ans.applied = 1'b1;
            end else begin
              ans.rejected_full = 1'b1;
            end
          end
        end
        usvt_pkg::KIND_ERASE: begin
          if (ans.was_present) begin
            held_count--;
            held_values[slot] = held_values[held_count];
            ans.applied = 1'b1;
          end
        end
        default: ;
      endcase
      ans.entry_count = held_count[COUNT_W-1:0];
      pending_answers.push_back(ans);
    endfunction

    // Compare one strobed result with the oldest queued answer
    function void check_answer(set_answer_t got);
      set_answer_t want;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result present=%0d applied=%0d full=%0d count=%0d",
                 $time, got.was_present, got.applied, got.rejected_full, got.entry_count);
        failures++;
        return;
      end
      want = pending_answers.pop_front();
      if (got.was_present !== want.was_present) begin
        $display("%0t: was_present mismatch: expected %0d, actual %0d",
                 $time, want.was_present, got.was_present);
        failures++;
      end
      if (got.applied !== want.applied) begin
        $display("%0t: applied mismatch: expected %0d, actual %0d",
                 $time, want.applied, got.applied);
        failures++;
      end
      if (got.rejected_full !== want.rejected_full) begin
        $display("%0t: rejected_full mismatch: expected %0d, actual %0d",
                 $time, want.rejected_full, got.rejected_full);
        failures++;
      end
      if (got.entry_count !== want.entry_count) begin
        $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                 $time, want.entry_count, got.entry_count);
        failures++;
      end
    endfunction
  endclass

  logic               clk   = 1'b0;
  logic               rst   = 1'b1;
  logic               start = 1'b0;
  logic [KIND_W-1:0]  kind  = '0;
  logic [VALUE_W-1:0] value = '0;
  logic               busy;
  logic               done;
  logic               was_present;
  logic               applied;
  logic               rejected_full;
  logic [COUNT_W-1:0] entry_count;

  value_set_scoreboard set_sb;
  logic [VALUE_W-1:0]  value_pool [POOL_SIZE];

  unique_value_set_table #(
    .CAPACITY_ENTRIES(SET_CAPACITY),
    .VALUE_BITS      (VALUE_W)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .value        (value),
    .done         (done),
    .was_present  (was_present),
    .applied      (applied),
    .rejected_full(rejected_full),
    .entry_count  (entry_count)
  );

  // Toggle the clock every half period
  always #2 clk = ~clk;

  // Check every strobed result against the prediction
  always @(posedge clk) begin
    if (!rst && done) set_sb.check_answer({was_present, applied, rejected_full, entry_count});
  end

  // Bound the run in case the block hangs
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Transfer one command; start stays high when the next one follows with no gap
  task automatic issue_command(input logic [KIND_W-1:0] op, input logic [VALUE_W-1:0] v,
                               input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    kind  <= op;
    value <= v;
    do @(posedge clk); while (busy);
    set_sb.apply_command(op, v);
  endtask

  // Hold start low until every queued answer has come back
  task automatic drain_answers();
    start <= 1'b0;
    @(posedge clk);
    while (set_sb.pending_answers.size() != 0) @(posedge clk);
  endtask

  // Pick a value: from the shared pool with the given percentage, else fully random
  function automatic logic [VALUE_W-1:0] pick_value(int pool_pct);
    if ($urandom_range(0, 99) < pool_pct) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // Pick an operation from weights for insert, erase and query; the rest are unassigned
  function automatic logic [KIND_W-1:0] pick_kind(int ins_pct, int era_pct, int qry_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) return usvt_pkg::KIND_INSERT;
    if (roll < ins_pct + era_pct) return usvt_pkg::KIND_ERASE;
    if (roll < ins_pct + era_pct + qry_pct) return usvt_pkg::KIND_QUERY;
    return KIND_OTHER;
  endfunction

  initial begin
    int issued;
    int phase_sel;
    int phase_len;
    int pool_pct;
    bit no_gaps;
    logic [KIND_W-1:0]  op;
    logic [VALUE_W-1:0] v;

    set_sb = new();
    value_pool[0] = '0;
    value_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) value_pool[i] = $urandom;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty set, extreme values, duplicates, unassigned code, swap on erase
    issue_command(usvt_pkg::KIND_QUERY,  32'h0000_0000, $urandom_range(0, 10));
    issue_command(usvt_pkg::KIND_ERASE,  32'h0000_0000, $urandom_range(0, 10));
    issue_command(usvt_pkg::KIND_INSERT, 32'h0000_0000, $urandom_range(0, 10));
    issue_command(usvt_pkg::KIND_INSERT, 32'hFFFF_FFFF, $urandom_range(0, 10));
    issue_command(usvt_pkg::KIND_INSERT, 32'h0000_0000, 0);
    issue_command(usvt_pkg::KIND_QUERY,  32'hFFFF_FFFF, 0);
    issue_command(KIND_OTHER,            32'h0000_0000, $urandom_range(0, 10));
    issue_command(KIND_OTHER,            32'h1234_5678, 0);
    issue_command(usvt_pkg::KIND_INSERT, 32'h0000_0001, 0);
    issue_command(usvt_pkg::KIND_INSERT, 32'h8000_0000, $urandom_range(0, 10));
    issue_command(usvt_pkg::KIND_INSERT, 32'h5555_AAAA, 0);
    issue_command(usvt_pkg::KIND_ERASE,  32'h0000_0000, 0);
    issue_command(usvt_pkg::KIND_QUERY,  32'h5555_AAAA, $urandom_range(0, 10));
    issue_command(usvt_pkg::KIND_ERASE,  32'h5555_AAAA, 0);
    issue_command(usvt_pkg::KIND_ERASE,  32'h8000_0000, 0);
    issue_command(usvt_pkg::KIND_QUERY,  32'h0000_0000, $urandom_range(0, 10));
    issue_command(usvt_pkg::KIND_ERASE,  32'hDEAD_BEEF, 0);
    issue_command(usvt_pkg::KIND_ERASE,  32'hFFFF_FFFF, 0);
    issue_command(usvt_pkg::KIND_ERASE,  32'h0000_0001, $urandom_range(0, 10));
    issue_command(usvt_pkg::KIND_QUERY,  32'h0000_0001, 0);
    drain_answers();

    // Random phases: fill toward capacity, drain, mix, and noise
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      phase_sel = $urandom_range(0, 3);
      phase_len = $urandom_range(20, 60);
      no_gaps   = ($urandom_range(0, 3) == 0);
      pool_pct  = (phase_sel == 3) ? 50 : 85;
      for (int n = 0; n < phase_len; n++) begin
        case (phase_sel)
          0:       op = pick_kind(70, 10, 15);
          1:       op = pick_kind(15, 65, 15);
          2:       op = pick_kind(35, 35, 25);
          default: op = KIND_W'($urandom_range(0, 3));
        endcase
        v = pick_value(pool_pct);
        // Aim about half of the erases in the drain phase at values actually held
        if (phase_sel == 1 && op == usvt_pkg::KIND_ERASE && set_sb.held_count > 0 &&
            $urandom_range(0, 1) == 1)
          v = set_sb.held_values[$urandom_range(0, set_sb.held_count - 1)];
        issue_command(op, v, no_gaps ? 0 : $urandom_range(0, 10));
        issued++;
      end
      if ($urandom_range(0, 2) == 0) drain_answers();
    end

    // Wait for the last answers, then let the block settle
    drain_answers();
    repeat (40) @(posedge clk);
    if (set_sb.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
